FILE: hdl/assembly_line_schedule_core_defines.svh
// Assertion macros shared by the assembly line schedule RTL.
// Users need signals named clk and arst_n in the scope of each use.
`ifndef ASSEMBLY_LINE_SCHEDULE_CORE_DEFINES_SVH
`define ASSEMBLY_LINE_SCHEDULE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ALS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/als_pkg.sv
// Shared types and constants for the assembly line schedule core.
// No dependencies; every RTL module imports this package.
package als_pkg;

	localparam int COST_W           = 24;
	localparam int TIME_W           = 16;
	localparam int STN_W            = 7;
	localparam int CFG_IDX_W        = 2;
	localparam int MAX_STATIONS_DEF = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRY_LINE1 = 2'd0,
		CFG_ENTRY_LINE2 = 2'd1,
		CFG_EXIT_LINE1  = 2'd2,
		CFG_EXIT_LINE2  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] work_line1;
		logic [TIME_W-1:0] work_line2;
		logic [TIME_W-1:0] move_from_line1;
		logic [TIME_W-1:0] move_from_line2;
		logic              is_last;
	} item_t;

	typedef struct packed {
		logic              chosen_line;
		logic [STN_W-1:0]  station_number;
		logic [COST_W-1:0] total_time;
		logic              overflow;
		logic              final_res;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic acs1;
		logic acs2;
		logic exit_sel;
		logic trace;
		logic prep;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic cnt_one;
		logic last;
		logic trace_done;
		logic emit_final;
	} sts_t;

endpackage

FILE: hdl/assembly_line_schedule_core.sv
// Two-line assembly line scheduler. The host presents one item per
// station on item and pulses start while busy is low; the item is
// taken at that edge. A normal station passes through both
// add-compare-select states; the first station and any station past
// capacity through the first only. On the item marked is_last the
// block picks the exit, traces back through the predecessor memory
// (one station a cycle) and reads back the path memory, then drives
// one result per station held, on consecutive cycles and each marked
// by strobe for one cycle, station 1 first, final_res set on the last.
// The receiver cannot stall. The traceback and readback take one
// memory read per cycle, which sets the length of that phase.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// taken at any edge, cfg_ready being always high; they belong between runs.
// Reset clears the cost registers, run state and configuration; the
// memories have no reset; every entry whose data is used was written first.
// Depends on als_pkg, als_ctrl, als_dp and the defines header.
`include "assembly_line_schedule_core_defines.svh"

module assembly_line_schedule_core #(
	parameter int MAX_STATIONS = als_pkg::MAX_STATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  als_pkg::item_t                item,
	output logic                          strobe,
	output als_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [als_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [als_pkg::TIME_W-1:0]    cfg_data
);
	import als_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	als_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.strobe (strobe),
		.sts    (sts),
		.cmd    (cmd)
	);

	als_dp #(
		.MAX_STATIONS (MAX_STATIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	`ALS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy.")
	`ALS_ASSERT_SAME(a_strobe_busy, strobe, busy, "Result strobe while not busy.")
	`ALS_ASSERT_NEXT(a_emit_run, strobe && !result.final_res, strobe && (result.station_number == $past(result.station_number) + 7'd1), "Result run broken.")
	`ALS_ASSERT_NEXT(a_final_idle, strobe && result.final_res, !busy && !strobe, "Block not idle after final result.")

endmodule

FILE: hdl/als_dp.sv
// Datapath of the assembly line schedule core: configuration registers,
// running costs, predecessor and path memories, traceback and result fields.
// Depends on als_pkg.
module als_dp #(
	parameter int MAX_STATIONS = als_pkg::MAX_STATIONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  als_pkg::cmd_t                   cmd,
	output als_pkg::sts_t                   sts,
	input  als_pkg::item_t                  item,
	input  logic                            cfg_we,
	input  logic [als_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [als_pkg::TIME_W-1:0]      cfg_data,
	output als_pkg::result_t                result
);
	import als_pkg::*;

	localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam logic [STN_W-1:0] CNT_MAX = STN_W'(MAX_STATIONS);
	localparam int SUM_W = COST_W + 1;

	item_t             item_q;
	logic [TIME_W-1:0] entry1_q, entry2_q, exit1_q, exit2_q;
	logic [COST_W-1:0] cost1_q, cost2_q, total_q;
	logic [STN_W-1:0]  cnt_q;
	logic              drop_q;
	logic [SUM_W-1:0]  base1_s1, base2_s1;
	logic [1:0]        from_s1;
	logic              line_q;
	logic [IDX_W-1:0]  ti_q, eo_q;
	logic [1:0]        cf_rd_q;
	logic              ps_rd_q;

	logic [1:0]        cf_mem [MAX_STATIONS];
	logic              ps_mem [MAX_STATIONS];

	logic [SUM_W-1:0]  via1, via2, sum1, sum2, t1, t2;
	logic              stay1, stay2, pick2, line_n;
	logic [STN_W-1:0]  cnt_m1, stn;
	logic [IDX_W-1:0]  ti_m1, cf_raddr, ps_raddr, ps_waddr;
	logic              ps_we, ps_wdata;

	assign via1  = {1'b0, cost1_q} + SUM_W'(item_q.move_from_line1);
	assign via2  = {1'b0, cost2_q} + SUM_W'(item_q.move_from_line2);
	assign stay1 = ({1'b0, cost1_q} <= via2);
	assign stay2 = ({1'b0, cost2_q} <= via1);
	assign sum1  = base1_s1 + SUM_W'(item_q.work_line1);
	assign sum2  = base2_s1 + SUM_W'(item_q.work_line2);
	assign t1    = {1'b0, cost1_q} + SUM_W'(exit1_q);
	assign t2    = {1'b0, cost2_q} + SUM_W'(exit2_q);
	assign pick2 = !(t1 <= t2);

	assign cnt_m1 = cnt_q - STN_W'(1);
	assign ti_m1  = ti_q - IDX_W'(1);
	assign stn    = STN_W'(eo_q) + STN_W'(1);
	// Bit 0 holds the predecessor of line 1, bit 1 that of line 2.
	assign line_n = cf_rd_q[line_q];

	assign cf_raddr = cmd.trace ? ti_m1 : cnt_m1[IDX_W-1:0];
	assign ps_raddr = cmd.emit ? (eo_q + IDX_W'(1)) : '0;
	assign ps_we    = cmd.exit_sel | cmd.trace;
	assign ps_waddr = cmd.trace ? ti_m1 : cnt_m1[IDX_W-1:0];
	assign ps_wdata = cmd.trace ? line_n : pick2;

	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.cnt_full   = (cnt_q >= CNT_MAX);
	assign sts.cnt_one    = (cnt_q == STN_W'(1));
	assign sts.last       = item_q.is_last;
	assign sts.trace_done = (ti_q == IDX_W'(1));
	assign sts.emit_final = (stn == cnt_q);

	assign result.chosen_line    = ps_rd_q;
	assign result.station_number = stn;
	assign result.total_time     = total_q;
	assign result.overflow       = drop_q;
	assign result.final_res      = (stn == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry1_q <= '0;
			entry2_q <= '0;
			exit1_q  <= '0;
			exit2_q  <= '0;
			cost1_q  <= '0;
			cost2_q  <= '0;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ENTRY_LINE1: entry1_q <= cfg_data;
					CFG_ENTRY_LINE2: entry2_q <= cfg_data;
					CFG_EXIT_LINE1:  exit1_q  <= cfg_data;
					CFG_EXIT_LINE2:  exit2_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acs1) begin
				if (sts.cnt_full) begin
					drop_q <= 1'b1;
				end else if (sts.cnt_zero) begin
					cost1_q <= COST_W'(entry1_q) + COST_W'(item_q.work_line1);
					cost2_q <= COST_W'(entry2_q) + COST_W'(item_q.work_line2);
					cnt_q   <= STN_W'(1);
				end
			end
			if (cmd.acs2) begin
				cost1_q <= sum1[COST_W-1:0];
				cost2_q <= sum2[COST_W-1:0];
				cnt_q   <= cnt_q + STN_W'(1);
			end
			// The run state clears as the last result of the run goes out.
			if (cmd.emit && sts.emit_final) begin
				cost1_q <= '0;
				cost2_q <= '0;
				cnt_q   <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.acs1) begin
			base1_s1 <= stay1 ? {1'b0, cost1_q} : via2;
			base2_s1 <= stay2 ? {1'b0, cost2_q} : via1;
			from_s1  <= {stay2, !stay1};
		end
		if (cmd.exit_sel) begin
			total_q <= pick2 ? t2[COST_W-1:0] : t1[COST_W-1:0];
			line_q  <= pick2;
			ti_q    <= cnt_m1[IDX_W-1:0];
		end
		if (cmd.trace) begin
			line_q <= line_n;
			ti_q   <= ti_m1;
		end
		if (cmd.prep) begin
			eo_q <= '0;
		end
		if (cmd.emit) begin
			eo_q <= eo_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acs2) begin
			cf_mem[cnt_q[IDX_W-1:0]] <= from_s1;
		end
		cf_rd_q <= cf_mem[cf_raddr];
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[ps_waddr] <= ps_wdata;
		end
		ps_rd_q <= ps_mem[ps_raddr];
	end

endmodule

FILE: hdl/als_ctrl.sv
// Controller of the assembly line schedule core: sequences the two
// add-compare-select steps, exit choice, traceback and result output.
// Depends on als_pkg.
module als_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          strobe,
	input  als_pkg::sts_t sts,
	output als_pkg::cmd_t cmd
);
	import als_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACS1,
		ST_ACS2,
		ST_EXIT,
		ST_TRACE,
		ST_PREP,
		ST_EMIT
	} state_t;

	state_t state_q, state_n;
	logic   busy_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = ST_ACS1;
				end
			end
			ST_ACS1: begin
				if (!sts.cnt_zero && !sts.cnt_full) begin
					state_n = ST_ACS2;
				end else begin
					state_n = sts.last ? ST_EXIT : ST_IDLE;
				end
			end
			ST_ACS2: begin
				state_n = sts.last ? ST_EXIT : ST_IDLE;
			end
			ST_EXIT: begin
				state_n = sts.cnt_one ? ST_PREP : ST_TRACE;
			end
			ST_TRACE: begin
				if (sts.trace_done) begin
					state_n = ST_PREP;
				end
			end
			ST_PREP: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.emit_final) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			busy_q  <= (state_n != ST_IDLE);
		end
	end

	assign busy   = busy_q;
	assign strobe = (state_q == ST_EMIT);

	assign cmd.load     = (state_q == ST_IDLE) && start;
	assign cmd.acs1     = (state_q == ST_ACS1);
	assign cmd.acs2     = (state_q == ST_ACS2);
	assign cmd.exit_sel = (state_q == ST_EXIT);
	assign cmd.trace    = (state_q == ST_TRACE);
	assign cmd.prep     = (state_q == ST_PREP);
	assign cmd.emit     = (state_q == ST_EMIT);

endmodule
